/* src/vpp_pkg.sv */
// shared widths, register codes, reset values and sideband type of the projection pipeline
`timescale 1ns / 1ps
package vpp_pkg;

  localparam int unsigned PosW     = 16;
  localparam int unsigned TexW     = 16;
  localparam int unsigned SlotW    = 2;
  localparam int unsigned ScrW     = 24;
  localparam int unsigned DepW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 60;
  localparam int unsigned MatW     = 48;
  localparam int unsigned TrW      = 60;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned OffW     = 20;
  localparam int unsigned OffShift = 13;
  localparam int unsigned ProdW    = 32;
  localparam int unsigned CamW     = 36;
  localparam int unsigned FocW     = 16;
  localparam int unsigned CenW     = 16;
  localparam int unsigned ScaledW  = CamW + FocW + 1;
  localparam int unsigned DivW     = 64;
  localparam int unsigned QuoBits  = 25;

  typedef enum logic [CfgIdxW-1:0] {
    RegRow0  = 3'd0,
    RegRow1  = 3'd1,
    RegRow2  = 3'd2,
    RegTrans = 3'd3,
    RegFocal = 3'd4,
    RegCx    = 3'd5,
    RegCy    = 3'd6
  } cfg_reg_e;

  localparam logic [MatW-1:0] Row0Reset  = 48'h0000_0000_2000;
  localparam logic [MatW-1:0] Row1Reset  = 48'h0000_2000_0000;
  localparam logic [MatW-1:0] Row2Reset  = 48'h2000_0000_0000;
  localparam logic [TrW-1:0]  TransReset = '0;
  localparam logic [FocW-1:0] FocalReset = 16'd256;
  localparam logic [CenW-1:0] CenReset   = '0;

  typedef struct packed {
    logic [TexW-1:0]  tex_u;
    logic [TexW-1:0]  tex_v;
    logic [SlotW-1:0] slot;
    logic             behind;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic             ovf_i;
  } side_t;

  // clamp to the signed 24-bit screen range
  function automatic logic signed [ScrW-1:0] sat_scr(input logic signed [QuoBits+2:0] v);
    logic signed [QuoBits+2:0] hi;
    logic signed [QuoBits+2:0] lo;
    hi = (QuoBits+3)'(2**(ScrW-1) - 1);
    lo = -(QuoBits+3)'(2**(ScrW-1));
    if (v > hi) return hi[ScrW-1:0];
    if (v < lo) return lo[ScrW-1:0];
    return v[ScrW-1:0];
  endfunction

endpackage

/* src/vpp_in_if.sv */
// vertex request channel
`timescale 1ns / 1ps
interface vpp_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [vpp_pkg::PosW-1:0]    pos_x;
  logic signed [vpp_pkg::PosW-1:0]    pos_y;
  logic signed [vpp_pkg::PosW-1:0]    pos_z;
  logic        [vpp_pkg::TexW-1:0]    tex_u;
  logic        [vpp_pkg::TexW-1:0]    tex_v;
  logic        [vpp_pkg::SlotW-1:0]   vertex_slot;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_slot, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_slot, output ready);
endinterface

/* src/vpp_out_if.sv */
// projected vertex result channel
`timescale 1ns / 1ps
interface vpp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vpp_pkg::ScrW-1:0]    screen_x;
  logic signed [vpp_pkg::ScrW-1:0]    screen_y;
  logic        [vpp_pkg::DepW-1:0]    inv_depth;
  logic        [vpp_pkg::TexW-1:0]    out_tex_u;
  logic        [vpp_pkg::TexW-1:0]    out_tex_v;
  logic        [vpp_pkg::SlotW-1:0]   out_slot;
  logic                               behind;
  modport source (output valid, screen_x, screen_y, inv_depth, out_tex_u, out_tex_v, out_slot,
                  behind, input ready);
  modport sink   (input valid, screen_x, screen_y, inv_depth, out_tex_u, out_tex_v, out_slot,
                  behind, output ready);
endinterface

/* src/vpp_divider.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module vpp_divider #(
  parameter int unsigned NumW  = vpp_pkg::DivW,
  parameter int unsigned QBits = vpp_pkg::QuoBits
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [NumW-1:0]  den_i,
  output logic [QBits-1:0] quo_o
);

  logic [NumW-1:0]  rem_q [QBits];
  logic [NumW-1:0]  den_q [QBits];
  logic [QBits-1:0] quo_q [QBits];
  logic [NumW-1:0]  rem_d [QBits];
  logic [QBits-1:0] quo_d [QBits];

  for (genvar k = 0; k < QBits; k++) begin : g_stage
    logic [NumW-1:0]  rin;
    logic [NumW-1:0]  din;
    logic [QBits-1:0] qin;
    logic [NumW-1:0]  dsh;
    logic             ge;
    if (k == 0) begin : g_first
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
    end
    always_comb begin
      dsh = din << (QBits - 1 - k);
      ge  = (rin >= dsh);
      rem_d[k] = ge ? (rin - dsh) : rin;
      quo_d[k] = qin;
      quo_d[k][QBits-1-k] = ge;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= din;
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[QBits-1];

endmodule

/* src/vertex_perspective_projection.sv */
// top level: vertex transform and perspective projection pipeline
//
//  channel  | dir | handshake     | payload
//  in_i     | in  | valid / ready | pos_x pos_y pos_z tex_u tex_v vertex_slot
//  out_o    | out | valid / ready | screen_x screen_y inv_depth out_tex_u out_tex_v out_slot behind
//  cfg      | in  | cfg_we_i      | cfg_idx_i cfg_data_i
//
// one request per cycle while out_o is not stalled; stages in order: products, sums,
// focal scale, divider set-up, 25 divider stages (one quotient bit each), output
// all stages advance together whenever the output register is empty or taken,
// so a stall holds every stage in place and nothing is lost or repeated
// reset clears the valid bits and loads the identity camera set-up
`timescale 1ns / 1ps
module vertex_perspective_projection (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vpp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [vpp_pkg::CfgDataW-1:0]   cfg_data_i,
  vpp_in_if.sink                         in_i,
  vpp_out_if.source                      out_o
);
  import vpp_pkg::*;

  localparam int unsigned QBits = QuoBits;
  localparam int unsigned QExtW = QBits + 3;

  // configuration registers
  logic [MatW-1:0] row_q [3];
  logic [TrW-1:0]  trans_q;
  logic [FocW-1:0] focal_q;
  logic [CenW-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= Row0Reset;
      row_q[1] <= Row1Reset;
      row_q[2] <= Row2Reset;
      trans_q  <= TransReset;
      focal_q  <= FocalReset;
      cx_q     <= CenReset;
      cy_q     <= CenReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegRow0:  row_q[0] <= cfg_data_i[MatW-1:0];
        RegRow1:  row_q[1] <= cfg_data_i[MatW-1:0];
        RegRow2:  row_q[2] <= cfg_data_i[MatW-1:0];
        RegTrans: trans_q  <= cfg_data_i[TrW-1:0];
        RegFocal: focal_q  <= cfg_data_i[FocW-1:0];
        RegCx:    cx_q     <= cfg_data_i[CenW-1:0];
        RegCy:    cy_q     <= cfg_data_i[CenW-1:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic out_v_q;
  logic en;
  assign en = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // valid chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic [QBits-1:0] vdiv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      vdiv_q  <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= in_i.valid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      vdiv_q  <= {vdiv_q[QBits-2:0], v4_q};
      out_v_q <= vdiv_q[QBits-1];
    end
  end

  // stage 1: nine coefficient products
  logic signed [ProdW-1:0] prod_q [3][3];
  side_t                   side1_q, side2_q, side3_q, side4_q;
  logic signed [PosW-1:0]  pos [3];
  side_t                   side_in;

  always_comb begin
    pos[0] = in_i.pos_x;
    pos[1] = in_i.pos_y;
    pos[2] = in_i.pos_z;
    side_in       = '0;
    side_in.tex_u = in_i.tex_u;
    side_in.tex_v = in_i.tex_v;
    side_in.slot  = in_i.vertex_slot;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(row_q[r][c*CoefW +: CoefW]) * pos[c];
        end
      end
      side1_q <= side_in;
    end
  end

  // stage 2: camera-space sums with offsets
  logic signed [CamW-1:0] cam_q [3];
  logic signed [CamW-1:0] cam_d [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cam_d[r] = CamW'(prod_q[r][0]) + CamW'(prod_q[r][1]) + CamW'(prod_q[r][2])
               + $signed({trans_q[r*OffW +: OffW], {OffShift{1'b0}}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cam_q   <= cam_d;
      side2_q <= side1_q;
    end
  end

  // stage 3: focal scaling, magnitudes, behind test
  logic signed [ScaledW-1:0] fx, fy;
  logic [ScaledW-1:0]        magx_q, magy_q;
  logic [CamW-1:0]           dep_q;
  side_t                     side3_d;

  always_comb begin
    fx = cam_q[0] * $signed({1'b0, focal_q});
    fy = cam_q[1] * $signed({1'b0, focal_q});
    side3_d        = side2_q;
    side3_d.behind = !cam_q[2][CamW-1];
    side3_d.neg_x  = fx[ScaledW-1];
    side3_d.neg_y  = fy[ScaledW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      magx_q  <= fx[ScaledW-1] ? ScaledW'(-fx) : ScaledW'(fx);
      magy_q  <= fy[ScaledW-1] ? ScaledW'(-fy) : ScaledW'(fy);
      dep_q   <= CamW'(-cam_q[2]);
      side3_q <= side3_d;
    end
  end

  // stage 4: rounded divider operands and overflow checks
  logic [DivW-1:0] numx_d, numy_d, numi_d, denp_d, deni_d;
  logic [DivW-1:0] numx_q, numy_q, numi_q, denp_q, deni_q;
  side_t           side4_d;

  always_comb begin
    denp_d = DivW'(dep_q) << 5;
    deni_d = DivW'(dep_q) << 1;
    numx_d = (DivW'(magx_q) << 1) + (DivW'(dep_q) << 4);
    numy_d = (DivW'(magy_q) << 1) + (DivW'(dep_q) << 4);
    numi_d = (DivW'(1) << CamW) + DivW'(dep_q);
    side4_d       = side3_q;
    side4_d.ovf_x = numx_d >= (denp_d << QBits);
    side4_d.ovf_y = numy_d >= (denp_d << QBits);
    side4_d.ovf_i = numi_d >= (deni_d << QBits);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_q  <= numx_d;
      numy_q  <= numy_d;
      numi_q  <= numi_d;
      denp_q  <= denp_d;
      deni_q  <= deni_d;
      side4_q <= side4_d;
    end
  end

  // divider stages
  logic [QBits-1:0] qx, qy, qi;

  vpp_divider #(.NumW(DivW), .QBits(QBits)) u_div_x (
    .clk_i, .en_i(en), .num_i(numx_q), .den_i(denp_q), .quo_o(qx)
  );
  vpp_divider #(.NumW(DivW), .QBits(QBits)) u_div_y (
    .clk_i, .en_i(en), .num_i(numy_q), .den_i(denp_q), .quo_o(qy)
  );
  vpp_divider #(.NumW(DivW), .QBits(QBits)) u_div_i (
    .clk_i, .en_i(en), .num_i(numi_q), .den_i(deni_q), .quo_o(qi)
  );

  // sideband travelling alongside the divider
  side_t side_div_q [QBits];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_div_q[0] <= side4_q;
      for (int k = 1; k < QBits; k++) side_div_q[k] <= side_div_q[k-1];
    end
  end

  // output stage: sign, centre offset, saturation, inverse-depth clamp, behind zeroing
  side_t                   sd;
  logic signed [QExtW-1:0] mx, my, sx_full, sy_full;
  logic [DepW-1:0]         idp;
  logic signed [ScrW-1:0]  sx_q, sy_q;
  logic [DepW-1:0]         idp_q;
  side_t                   sout_q;

  always_comb begin
    sd = side_div_q[QBits-1];
    // an overflowed quotient stands in as the first out-of-range value
    mx = sd.ovf_x ? (QExtW'(1) << QBits) : QExtW'(qx);
    my = sd.ovf_y ? (QExtW'(1) << QBits) : QExtW'(qy);
    sx_full = (sd.neg_x ? -mx : mx) + QExtW'(cx_q);
    sy_full = (sd.neg_y ? my : -my) + QExtW'(cy_q);
    if (sd.ovf_i || (qi > QBits'({DepW{1'b1}}))) idp = '1;
    else                                         idp = qi[DepW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sout_q <= sd;
      if (sd.behind) begin
        sx_q  <= '0;
        sy_q  <= '0;
        idp_q <= '0;
      end else begin
        sx_q  <= sat_scr(sx_full);
        sy_q  <= sat_scr(sy_full);
        idp_q <= idp;
      end
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.screen_x  = sx_q;
  assign out_o.screen_y  = sy_q;
  assign out_o.inv_depth = idp_q;
  assign out_o.out_tex_u = sout_q.tex_u;
  assign out_o.out_tex_v = sout_q.tex_v;
  assign out_o.out_slot  = sout_q.slot;
  assign out_o.behind    = sout_q.behind;

endmodule
